/* rtl/shs_pkg.sv */
// ----------------------------------------------------------------------------
// shs_pkg: shared types and constants of the streaming SHA-256 hasher
// Holds the round constants, the initial hash value, the hash word array
// type and the command group passed from the sequencer to the round core.
// ----------------------------------------------------------------------------
`default_nettype none

package shs_pkg;

  localparam int WORD_W   = 32;
  localparam int ROUNDS   = 64;
  localparam int BLOCK_W  = 512;

  // Eight hash words, index 0 is the first (most significant) digest word.
  typedef logic [7:0][WORD_W-1:0] hash_t;

  // Rightmost element is index 0.
  localparam hash_t INIT_H = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST = 3'd7;

  // Commands from the sequencer to the round core.
  typedef struct packed {
    logic       init;        // reload the initial hash value
    logic       shift_byte;  // shift one byte into the block buffer
    logic [7:0] byte_val;    // byte to shift in
    logic       start;       // begin a 64-round compression
  } core_cmd_t;

endpackage

`default_nettype wire

/* rtl/shs_if.sv */
// ----------------------------------------------------------------------------
// shs_if: stream channels of the SHA-256 hasher
// Message byte channel and digest word channel, each with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface shs_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output has_byte, output is_last,
                  input ready);
  modport sink (input valid, input data_byte, input has_byte, input is_last,
                output ready);
endinterface

interface shs_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_index,
                input last_word, output ready);
endinterface

`default_nettype wire

/* rtl/shs_core.sv */
// ----------------------------------------------------------------------------
// shs_core: block buffer, message schedule and shared round unit
// Bytes shift into a 512-bit buffer that doubles as the 16-word schedule
// window. One round per cycle, then a fold into the hash words.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire shs_pkg::core_cmd_t cmd,
  output logic                   done,
  output shs_pkg::hash_t         hash
);
  import shs_pkg::*;

  logic [BLOCK_W-1:0] blk;
  hash_t              v;
  hash_t              v_next;
  logic [6:0]         rnd;
  logic               busy;
  logic               run;
  logic [WORD_W-1:0]  w0, w1, w9, w14, w_new;
  logic [WORD_W-1:0]  t1, t2, a, e;

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                             input int n);
    rotr = (x >> n) | (x << (WORD_W - n));
  endfunction

  // The oldest schedule word sits at the top of the buffer.
  assign w0  = blk[BLOCK_W-1      -: WORD_W];
  assign w1  = blk[BLOCK_W-1-32   -: WORD_W];
  assign w9  = blk[BLOCK_W-1-288  -: WORD_W];
  assign w14 = blk[BLOCK_W-1-448  -: WORD_W];

  assign run  = busy && !rnd[6];
  assign done = busy && rnd[6];

  always_comb begin
    w_new = (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10)) + w9 +
            (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3)) + w0;
    a  = v[0];
    e  = v[4];
    t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
         ((e & v[5]) ^ (~e & v[6])) + ROUND_K[rnd[5:0]] + w0;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
         ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
    v_next = {v[6], v[5], v[4], v[3] + t1, v[2], v[1], v[0], t1 + t2};
  end

  // Buffer and working variables carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.shift_byte) begin
      blk <= {blk[BLOCK_W-9:0], cmd.byte_val};
    end else if (run) begin
      blk <= {blk[BLOCK_W-WORD_W-1:0], w_new};
    end
    if (cmd.start) begin
      v <= hash;
    end else if (run) begin
      v <= v_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= INIT_H;
      busy <= 1'b0;
      rnd  <= '0;
    end else begin
      if (cmd.init) begin
        hash <= INIT_H;
      end else if (done) begin
        for (int i = 0; i < 8; i++) begin
          hash[i] <= hash[i] + v[i];
        end
      end
      if (cmd.start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (done) begin
        busy <= 1'b0;
      end else if (busy) begin
        rnd <= rnd + 7'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/sha256_stream_hasher.sv */
// ----------------------------------------------------------------------------
// sha256_stream_hasher: streaming SHA-256 over a byte stream
// Takes one message byte per beat and returns the eight digest words of
// each message once its end marker has arrived.
// ----------------------------------------------------------------------------
// Usage:
// The msg channel carries one beat per byte. data_byte is used only when
// has_byte is set; is_last ends the message, and a beat with has_byte low
// and is_last high ends a message without adding a byte, so an empty
// message can be hashed. A beat with both flags low is taken and ignored.
// The digest channel returns eight beats per message, word_index 0 to 7,
// most significant word first, with last_word set on the eighth.
// Throughput: one byte beat is taken per cycle while msg.ready is high.
// Every 64th byte starts a compression (64 rounds through the single round
// unit, then a fold into the hash words), during which msg.ready is low.
// After the end marker the padding bytes are shifted in one per cycle up
// to the end of the block (one more block when fewer than nine bytes
// remain), each block is then compressed, and the digest follows.
// While the digest is offered no message beat is taken; a stalled receiver
// simply holds the block in that state, and the current word stays put.
// After the eighth word is taken the hash state is reinitialized.
// Reset (rst, synchronous) restores the initial hash value and clears the
// byte count and bit length; the block buffer needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher (
  input  wire logic   clk,
  input  wire logic   rst,
  shs_msg_if.sink     msg,
  shs_digest_if.source digest
);
  import shs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_COMP = 4'b0010,
    ST_PAD  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t      state;
  state_t      after_comp;   // where to go once the running compression ends
  logic [5:0]  fill;         // bytes in the current block
  logic [63:0] message_bits; // message length in bits, wraps naturally
  logic        mark_sent;    // the 0x80 padding byte is already in
  logic        final_blk;    // the length field fits into this block
  logic [2:0]  word_idx;

  core_cmd_t   cmd;
  logic        core_done;
  hash_t       hash;

  logic        msg_acc;
  logic        out_acc;
  logic        byte_in;
  logic [2:0]  len_shift;
  logic [7:0]  pad_byte;
  logic        len_phase;

  shs_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .done (core_done),
    .hash (hash)
  );

  assign msg.ready = (state == ST_IDLE);
  assign msg_acc   = msg.valid && msg.ready;
  assign byte_in   = msg_acc && msg.has_byte;

  assign digest.valid       = (state == ST_OUT);
  assign digest.digest_word = hash[word_idx];
  assign digest.word_index  = word_idx;
  assign digest.last_word   = (word_idx == WORD_LAST);
  assign out_acc            = digest.valid && digest.ready;

  // Padding byte: the mark first, then zeros, and the big-endian bit
  // length in the last eight bytes of the final block.
  assign len_phase = final_blk && (fill >= LEN_START);
  assign len_shift = WORD_LAST - fill[2:0];

  always_comb begin
    if (!mark_sent) begin
      pad_byte = PAD_MARK;
    end else if (len_phase) begin
      pad_byte = message_bits[8*len_shift +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.shift_byte = byte_in;
        cmd.byte_val   = msg.data_byte;
        cmd.start      = byte_in && (fill == FILL_LAST);
      end
      ST_PAD: begin
        cmd.shift_byte = 1'b1;
        cmd.byte_val   = pad_byte;
        cmd.start      = (fill == FILL_LAST);
      end
      ST_OUT: begin
        cmd.init = out_acc && (word_idx == WORD_LAST);
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      after_comp   <= ST_IDLE;
      fill         <= '0;
      message_bits <= '0;
      mark_sent    <= 1'b0;
      final_blk    <= 1'b0;
      word_idx     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (msg_acc) begin
            if (msg.has_byte) begin
              fill         <= fill + 6'd1;
              message_bits <= message_bits + 64'd8;
            end
            mark_sent <= 1'b0;
            if (byte_in && (fill == FILL_LAST)) begin
              state      <= ST_COMP;
              after_comp <= msg.is_last ? ST_PAD : ST_IDLE;
            end else if (msg.is_last) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          fill <= fill + 6'd1;
          if (!mark_sent) begin
            mark_sent <= 1'b1;
          end
          if (fill == FILL_LAST) begin
            state <= ST_COMP;
            // A mark placed in the last byte means the length goes into
            // a following block.
            if (mark_sent && final_blk) begin
              after_comp <= ST_OUT;
            end else begin
              after_comp <= ST_PAD;
              final_blk  <= 1'b1;
            end
          end else if (!mark_sent) begin
            final_blk <= (fill < LEN_START);
          end
        end
        ST_COMP: begin
          if (core_done) begin
            state <= after_comp;
          end
        end
        ST_OUT: begin
          if (out_acc) begin
            word_idx <= word_idx + 3'd1;
            if (word_idx == WORD_LAST) begin
              state        <= ST_IDLE;
              fill         <= '0;
              message_bits <= '0;
              mark_sent    <= 1'b0;
              final_blk    <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* bench/tb_sha256_stream_hasher.sv */
// ----------------------------------------------------------------------------
// tb_sha256_stream_hasher: self-checking bench for the streaming SHA-256 hasher
// Drives message beats with random gaps and checks each returned digest word
// against a SHA-256 computation done inside the bench. Covers empty messages,
// ignored beats, padding at the block edges, long back pressure and a stretch
// of full rate on both channels.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher;

  import shs_pkg::*;

  // Message beats to offer in the whole run, ignored beats included.
  localparam int unsigned ITEM_TARGET   = 380;
  // Chance in percent that a channel idles in a given cycle.
  localparam int unsigned IDLE_PCT      = 33;
  // Length of the long receiver hold-off, in cycles.
  localparam int unsigned STALL_CYCLES  = 300;
  // Quiet time after the last digest: two compressions plus padding and slack.
  localparam int unsigned SETTLE_CYCLES = 250;
  localparam int unsigned BLOCK_BYTES   = 64;
  localparam int unsigned LEN_FIELD_AT  = 56;
  localparam logic [7:0]  PAD_BYTE      = 8'h80;
  localparam logic [2:0]  FINAL_POS     = 3'd7;

  // The bench keeps its own copy of the round constants and the initial hash
  // value, so a wrong entry in the design's tables cannot hide itself.
  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // One digest beat as the bench expects to see it.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  pos;
    logic        last;
  } digest_beat_t;

  logic clk;
  logic rst;

  shs_msg_if    msg_ch ();
  shs_digest_if dig_ch ();

  sha256_stream_hasher dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .digest (dig_ch)
  );

  // Running hash of the message in flight, as the bench sees it.
  logic [31:0]  hash_state [8];
  logic [7:0]   block_bytes [64];
  int unsigned  block_fill;
  logic [63:0]  message_bit_len;

  // Digest words still owed by the design, oldest first.
  digest_beat_t pending_words [$];
  digest_beat_t want;

  int unsigned  fail_count;
  int unsigned  items_sent;
  int unsigned  messages_sent;
  int unsigned  words_checked;

  // full_rate turns off the random idling on both channels. stall_request
  // asks the receiver to hold ready low for STALL_CYCLES; only the test sets
  // it and only the receiver clears it.
  bit full_rate;
  bit stall_request;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Generous ceiling: the slowest correct run needs well under a tenth of it.
  initial begin
    #4000000;
    $display("sha256_stream_hasher: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // SHA-256 computation of the expected digests
  // --------------------------------------------------------------------------

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 8; i++) hash_state[i] = SHA_H0[i];
    block_fill      = 0;
    message_bit_len = '0;
  endfunction

  // Runs the 64 rounds over the buffered block and folds the result into
  // the hash state.
  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) begin
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0   = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1   = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + SHA_K[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endfunction

  function automatic void store_byte(input logic [7:0] value);
    block_bytes[block_fill] = value;
    block_fill++;
  endfunction

  // Applies one accepted message beat. An end marker pads the message, adds
  // the bit length and queues the eight digest words it must produce.
  function automatic void absorb_beat(input logic [7:0] value, input logic with_byte,
                                      input logic end_mark);
    digest_beat_t beat;
    if (with_byte) begin
      store_byte(value);
      message_bit_len += 64'd8;
      if (block_fill == BLOCK_BYTES) begin
        compress_block();
        block_fill = 0;
      end
    end
    if (!end_mark) return;

    store_byte(PAD_BYTE);
    // No room for the length field: finish this block with zeros first.
    if (block_fill > LEN_FIELD_AT) begin
      while (block_fill < BLOCK_BYTES) store_byte(8'h00);
      compress_block();
      block_fill = 0;
    end
    while (block_fill < LEN_FIELD_AT) store_byte(8'h00);
    for (int i = 0; i < 8; i++) store_byte(message_bit_len[63 - 8*i -: 8]);
    compress_block();

    for (int i = 0; i < 8; i++) begin
      beat.word = hash_state[i];
      beat.pos  = 3'(i);
      beat.last = (3'(i) == FINAL_POS);
      pending_words.push_back(beat);
    end
    restart_message();
  endfunction

  // --------------------------------------------------------------------------
  // Message channel driver
  // --------------------------------------------------------------------------

  // Offers one beat, after a random gap unless full rate is on, and returns
  // once the design has taken it. valid is left high so that back-to-back
  // beats need no second assignment in the same step.
  task automatic offer_beat(input logic [7:0] value, input logic with_byte,
                            input logic end_mark);
    int unsigned gap;
    gap = 0;
    if (!full_rate) begin
      while ($urandom_range(0, 99) < IDLE_PCT) gap++;
    end
    if (gap != 0) begin
      msg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_ch.valid     <= 1'b1;
    msg_ch.data_byte <= value;
    msg_ch.has_byte  <= with_byte;
    msg_ch.is_last   <= end_mark;
    @(posedge clk);
    while (!msg_ch.ready) @(posedge clk);
    absorb_beat(value, with_byte, end_mark);
    items_sent++;
  endtask

  // Sends one message of random bytes. The end is marked on the last byte,
  // or by a bare end marker when asked for or when the message is empty.
  // noise_pct is the chance of an ignored beat ahead of each byte.
  task automatic send_message(input int unsigned n_bytes, input bit bare_end,
                              input int unsigned noise_pct);
    for (int unsigned i = 0; i < n_bytes; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        offer_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      offer_beat(8'($urandom_range(0, 255)), 1'b1, !bare_end && (i == n_bytes - 1));
    end
    if (bare_end || n_bytes == 0) offer_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    messages_sent++;
  endtask

  // Stops offering and waits until every owed digest word has come back.
  task automatic drain_digests();
    msg_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Digest channel: receiver and checker
  // --------------------------------------------------------------------------

  initial begin : digest_receiver
    int unsigned hold_left;
    hold_left    = 0;
    dig_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        hold_left     = STALL_CYCLES;
        stall_request = 1'b0;
      end
      if (hold_left != 0) begin
        dig_ch.ready <= 1'b0;
        hold_left--;
      end else if (full_rate) begin
        dig_ch.ready <= 1'b1;
      end else begin
        dig_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Every digest beat taken is matched against the oldest owed word.
  always @(posedge clk) begin
    if (!rst && dig_ch.valid === 1'b1 && dig_ch.ready === 1'b1) begin
      if (pending_words.size() == 0) begin
        $error("digest beat with none owed: digest_word %h word_index %0d last_word %b",
               dig_ch.digest_word, dig_ch.word_index, dig_ch.last_word);
        fail_count++;
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (dig_ch.digest_word !== want.word) begin
          $error("digest_word: expected %h, got %h", want.word, dig_ch.digest_word);
          fail_count++;
        end
        if (dig_ch.word_index !== want.pos) begin
          $error("word_index: expected %0d, got %0d", want.pos, dig_ch.word_index);
          fail_count++;
        end
        if (dig_ch.last_word !== want.last) begin
          $error("last_word: expected %b, got %b", want.last, dig_ch.last_word);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Short hand-picked messages: empty ones, ignored beats, the extreme byte
  // values and both ways of ending a message.
  task automatic test_directed();
    // Empty message, twice in a row so the reinitialized state is used at once.
    offer_beat(8'h00, 1'b0, 1'b1);
    offer_beat(8'hff, 1'b0, 1'b1);
    // Ignored beats must leave the hash untouched; then "abc".
    offer_beat(8'hff, 1'b0, 1'b0);
    offer_beat(8'h00, 1'b0, 1'b0);
    offer_beat(8'h61, 1'b1, 1'b0);
    offer_beat(8'h62, 1'b1, 1'b0);
    offer_beat(8'hff, 1'b0, 1'b0);
    offer_beat(8'h63, 1'b1, 1'b1);
    // Single bytes at the extremes, each ending its own message.
    offer_beat(8'hff, 1'b1, 1'b1);
    offer_beat(8'h00, 1'b1, 1'b1);
    // Two extreme bytes closed by a bare end marker.
    offer_beat(8'h00, 1'b1, 1'b0);
    offer_beat(8'hff, 1'b1, 1'b0);
    offer_beat(8'h55, 1'b0, 1'b1);
    // A byte that looks like the pad marker, then an ignored beat and the end.
    offer_beat(PAD_BYTE, 1'b1, 1'b0);
    offer_beat(8'haa, 1'b0, 1'b0);
    offer_beat(8'h00, 1'b0, 1'b1);
    messages_sent += 7;
    drain_digests();
  endtask

  // Lengths around the block edges: 55 bytes leave just room for the length
  // field, 56 force a second padding block, 64 fill the block exactly.
  task automatic test_block_edges();
    send_message(55, 1'b0, 0);
    send_message(56, 1'b1, 0);
    send_message(64, 1'b0, 0);
    drain_digests();
  endtask

  // The receiver holds off for a long time while short messages keep coming,
  // so digests back up and the design must stop taking message beats.
  task automatic test_digest_backpressure();
    stall_request = 1'b1;
    for (int i = 0; i < 6; i++) begin
      send_message($urandom_range(0, 4), 1'($urandom_range(0, 1)), 0);
    end
    drain_digests();
  endtask

  // No idling on either side: bytes back to back across a compression.
  task automatic test_full_rate();
    full_rate = 1'b1;
    send_message(70, 1'b0, 0);
    send_message(3, 1'b1, 0);
    send_message(0, 1'b1, 0);
    drain_digests();
    full_rate = 1'b0;
  endtask

  // Random messages, mostly short, some across one or two block boundaries,
  // with a sprinkling of ignored beats, until the beat budget is spent.
  task automatic test_random_messages();
    int unsigned len;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) < 6) len = $urandom_range(0, 12);
      else len = $urandom_range(50, 130);
      if (len > ITEM_TARGET - items_sent) len = ITEM_TARGET - items_sent;
      send_message(len, $urandom_range(0, 3) == 0, 8);
    end
    drain_digests();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    msg_ch.valid     = 1'b0;
    msg_ch.data_byte = 8'h00;
    msg_ch.has_byte  = 1'b0;
    msg_ch.is_last   = 1'b0;
    rst              = 1'b1;
    full_rate        = 1'b0;
    stall_request    = 1'b0;
    fail_count       = 0;
    items_sent       = 0;
    messages_sent    = 0;
    words_checked    = 0;
    restart_message();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_block_edges();
    test_digest_backpressure();
    test_full_rate();
    test_random_messages();

    // Anything the design still sends now is flagged by the checker.
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Hashed %0d messages from %0d beats; %0d digest words compared.",
             messages_sent, items_sent, words_checked);
    $display("Covered empty and edge-length messages, ignored beats and back pressure.");
    if (fail_count == 0) begin
      $display("sha256_stream_hasher: match");
    end else begin
      $display("sha256_stream_hasher: mismatch");
    end
    $finish;
  end

endmodule
